FILE: rtl/srr_pkg.sv
// ----------------------------------------------------------------------------
// srr_pkg: shared types and codes for the selective-reject receiver
// Frame/result payload structs, queue command format and message codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srr_pkg;

	localparam int unsigned WINDOW_DEPTH_DEF  = 16;
	localparam int unsigned PAYLOAD_WIDTH_DEF = 32;
	localparam int unsigned QUEUE_DEPTH_DEF   = 4;

	// fixed field widths
	localparam int unsigned SEQ_W  = 32;
	localparam int unsigned WORD_W = 32;

	// frame kinds
	localparam logic FRAME_DATA = 1'b0;
	localparam logic FRAME_EOF  = 1'b1;

	// result message kinds
	localparam logic [1:0] KIND_DELIVER = 2'd0;
	localparam logic [1:0] KIND_RR      = 2'd1;
	localparam logic [1:0] KIND_SREJ    = 2'd2;
	localparam logic [1:0] KIND_EOFACK  = 2'd3;

	// queue command opcodes
	localparam logic [2:0] OP_RR_DLV = 3'd0;  // RR then deliver
	localparam logic [2:0] OP_STORE  = 3'd1;  // buffer frame, optional SREJ
	localparam logic [2:0] OP_STALE  = 3'd2;  // optional SREJ, then RR
	localparam logic [2:0] OP_EOF    = 3'd3;  // EOF ack
	localparam logic [2:0] OP_DRAIN  = 3'd4;  // buffer frame, then drain window

	typedef struct packed {
		logic              kind;
		logic [SEQ_W-1:0]  seq_num;
		logic [WORD_W-1:0] payload_word;
	} frame_t;

	typedef struct packed {
		logic [1:0]        msg_kind;
		logic [SEQ_W-1:0]  number;
		logic [WORD_W-1:0] payload_out;
		logic              last;
	} result_t;

	typedef struct packed {
		logic [2:0]       op;
		logic             srej;    // SREJ goes out with this command
		logic [SEQ_W-1:0] number;  // RR/SREJ number, or drain span
		logic [SEQ_W-1:0] seq;
	} cmd_t;

	typedef struct packed {
		logic             done;
		logic [SEQ_W-1:0] next_expected;
		logic             srej_sent;
	} drain_done_t;

endpackage

FILE: rtl/srr_ram.sv
// ----------------------------------------------------------------------------
// srr_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srr_ram #(
	parameter  int unsigned WIDTH = 32,
	parameter  int unsigned DEPTH = 16,
	localparam int unsigned AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: rtl/srr_cmd_fifo.sv
// ----------------------------------------------------------------------------
// srr_cmd_fifo: command queue between classifier and executor
// Small register FIFO with occupancy count, combinational head read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srr_cmd_fifo #(
	parameter  int unsigned WIDTH = 8,
	parameter  int unsigned DEPTH = 4,
	localparam int unsigned AW    = $clog2(DEPTH),
	localparam int unsigned CW    = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty,
	output logic [CW-1:0]    count
);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data = entry_q[rd_ptr_q];
	assign empty    = (count_q == '0);
	assign count    = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> count_q < CW'(DEPTH))
		else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("command queue underflow");

	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count lost a push");

endmodule

FILE: rtl/srr_front.sv
// ----------------------------------------------------------------------------
// srr_front: frame classifier
// Accepts frames, classifies them against the window state, updates that
// state, computes the store slot (seq mod depth) and queues a command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srr_front #(
	parameter  int unsigned WINDOW_DEPTH  = srr_pkg::WINDOW_DEPTH_DEF,
	parameter  int unsigned PAYLOAD_WIDTH = srr_pkg::PAYLOAD_WIDTH_DEF,
	parameter  int unsigned QUEUE_DEPTH   = srr_pkg::QUEUE_DEPTH_DEF,
	localparam int unsigned SW  = $clog2(WINDOW_DEPTH),
	localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1),
	localparam int unsigned QW  = $bits(srr_pkg::cmd_t) + PAYLOAD_WIDTH + SW
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  srr_pkg::frame_t       frame,
	input  logic [QCW-1:0]        q_count,
	output logic                  push,
	output logic [QW-1:0]         push_data,
	input  srr_pkg::drain_done_t  drain_done
);

	// seq mod depth: seq = hi*2^16 + lo, x = hi*(2^16 mod depth) + lo < 2^16*depth,
	// then x mod depth by reciprocal multiply with one correction step.
	localparam int unsigned HALF_W    = srr_pkg::SEQ_W / 2;
	localparam int unsigned XW        = HALF_W + SW;
	localparam int unsigned HI_WEIGHT = (32'd1 << HALF_W) % WINDOW_DEPTH;
	localparam logic [63:0]  RECIP     = (64'd1 << XW) / 64'(WINDOW_DEPTH);
	localparam logic [XW-1:0] RECIP_W  = RECIP[XW-1:0];
	localparam int unsigned OW        = QCW + 1;

	logic [srr_pkg::SEQ_W-1:0] exp_q;
	logic [srr_pkg::SEQ_W-1:0] high_q;
	logic                      srej_q;
	logic                      drain_pend_q;

	logic                      v_s1;
	logic                      v_s2;
	srr_pkg::cmd_t             cmd_s1;
	srr_pkg::cmd_t             cmd_s2;
	logic [PAYLOAD_WIDTH-1:0]  pay_s1;
	logic [PAYLOAD_WIDTH-1:0]  pay_s2;
	logic [XW-1:0]             x_s1;
	logic [XW-1:0]             x_s2;
	logic [HALF_W-1:0]         quo_s2;

	logic                      accept;
	logic [OW-1:0]             occupancy;
	logic                      cls_valid;
	srr_pkg::cmd_t             cls_cmd;
	logic [srr_pkg::SEQ_W-1:0] exp_d;
	logic [srr_pkg::SEQ_W-1:0] high_d;
	logic                      srej_d;
	logic                      pend_d;
	logic [PAYLOAD_WIDTH-1:0]  pay_in;
	logic [XW-1:0]             x_in;
	logic [2*XW-1:0]           prod;
	logic [XW-1:0]             qd;
	logic [XW-1:0]             rem;
	logic [SW-1:0]             slot;
	logic [srr_pkg::SEQ_W-1:0] seq;

	// stage count keeps queue from overflowing with items in flight
	assign occupancy = OW'(q_count) + OW'(v_s1) + OW'(v_s2);
	assign busy      = drain_pend_q | (occupancy >= OW'(QUEUE_DEPTH));
	assign accept    = start & ~busy;
	assign seq       = frame.seq_num;

	always_comb begin
		cls_valid = 1'b0;
		cls_cmd   = '0;
		exp_d     = exp_q;
		high_d    = high_q;
		srej_d    = srej_q;
		pend_d    = drain_pend_q;
		cls_cmd.seq = seq;
		if (frame.kind == srr_pkg::FRAME_DATA) begin
			cls_valid = 1'b1;
			if (seq == exp_q) begin
				if (seq >= high_q) begin
					cls_cmd.op     = srr_pkg::OP_RR_DLV;
					cls_cmd.number = seq + 1'b1;
					exp_d          = seq + 1'b1;
					high_d         = seq;
				end else begin
					// recovered frame: back end drains and reports new expected
					cls_cmd.op     = srr_pkg::OP_DRAIN;
					cls_cmd.number = high_q - seq;
					pend_d         = 1'b1;
				end
			end else if (seq > exp_q) begin
				cls_cmd.op     = srr_pkg::OP_STORE;
				cls_cmd.srej   = ~srej_q;
				cls_cmd.number = exp_q;
				srej_d         = 1'b1;
				if (seq > high_q) begin
					high_d = seq;
				end
			end else begin
				cls_cmd.op     = srr_pkg::OP_STALE;
				cls_cmd.srej   = (high_q > exp_q);
				cls_cmd.number = exp_q;
				if (high_q > exp_q) begin
					srej_d = 1'b1;
				end
			end
		end else if ((exp_q > high_q) || (exp_q == '0 && high_q == '0)) begin
			cls_valid  = 1'b1;
			cls_cmd.op = srr_pkg::OP_EOF;
		end
	end

	always_comb begin
		pay_in = '0;
		for (int b = 0; b < PAYLOAD_WIDTH; b++) begin
			if (b < srr_pkg::WORD_W) begin
				pay_in[b] = frame.payload_word[b];
			end
		end
	end

	assign x_in = XW'(seq[srr_pkg::SEQ_W-1:HALF_W]) * XW'(HI_WEIGHT) + XW'(seq[HALF_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q        <= '0;
			high_q       <= '0;
			srej_q       <= 1'b0;
			drain_pend_q <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
		end else begin
			if (accept) begin
				exp_q        <= exp_d;
				high_q       <= high_d;
				srej_q       <= srej_d;
				drain_pend_q <= pend_d;
			end else if (drain_done.done) begin
				exp_q        <= drain_done.next_expected;
				srej_q       <= drain_done.srej_sent;
				drain_pend_q <= 1'b0;
			end
			v_s1 <= accept & cls_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cls_cmd;
			pay_s1 <= pay_in;
			x_s1   <= x_in;
		end
		cmd_s2 <= cmd_s1;
		pay_s2 <= pay_s1;
		x_s2   <= x_s1;
		quo_s2 <= prod[XW+HALF_W-1:XW];
	end

	assign prod = (2*XW)'(x_s1) * (2*XW)'(RECIP_W);
	// quotient estimate is exact or one low
	assign qd   = XW'(quo_s2) * XW'(WINDOW_DEPTH);
	assign rem  = x_s2 - qd;
	assign slot = (rem >= XW'(WINDOW_DEPTH)) ? SW'(rem - XW'(WINDOW_DEPTH)) : SW'(rem);

	assign push      = v_s2;
	assign push_data = {slot, pay_s2, cmd_s2};

	a_drain_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cls_valid && cls_cmd.op == srr_pkg::OP_DRAIN |=> busy)
		else $error("accepted a frame during a pending drain");

	a_slot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> slot < SW'(WINDOW_DEPTH - 1) || slot == SW'(WINDOW_DEPTH - 1))
		else $error("slot index out of window");

	a_done_only_pending: assert property (@(posedge clk) disable iff (!arst_n)
		drain_done.done |-> drain_pend_q)
		else $error("drain completion without pending drain");

endmodule

FILE: rtl/srr_back.sv
// ----------------------------------------------------------------------------
// srr_back: command executor
// Pops queued commands, owns the window store and its valid bits, drains
// buffered frames in order and drives the registered result port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srr_back #(
	parameter  int unsigned WINDOW_DEPTH  = srr_pkg::WINDOW_DEPTH_DEF,
	parameter  int unsigned PAYLOAD_WIDTH = srr_pkg::PAYLOAD_WIDTH_DEF,
	localparam int unsigned SW = $clog2(WINDOW_DEPTH),
	localparam int unsigned QW = $bits(srr_pkg::cmd_t) + PAYLOAD_WIDTH + SW
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	output logic                 pop,
	input  logic [QW-1:0]        pop_data,
	output srr_pkg::drain_done_t drain_done,
	output srr_pkg::result_t     result,
	output logic                 result_strobe
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EMIT2 = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DEND  = 2'd3;

	logic [1:0]                 state_q;
	srr_pkg::result_t           out_q;
	logic                       strobe_q;
	srr_pkg::result_t           msg2_q;
	logic [srr_pkg::SEQ_W-1:0]  i_q;
	logic [srr_pkg::SEQ_W-1:0]  rem_q;
	logic [SW-1:0]              dslot_q;
	logic                       srej_pend_q;
	logic                       hole_q;
	logic [WINDOW_DEPTH-1:0]    valid_q;
	logic                       dlv_v_s1;
	logic [srr_pkg::SEQ_W-1:0]  dlv_seq_s1;

	logic [1:0]                 state_d;
	srr_pkg::result_t           out_d;
	logic                       strobe_d;
	srr_pkg::result_t           msg2_d;
	logic [srr_pkg::SEQ_W-1:0]  i_d;
	logic [srr_pkg::SEQ_W-1:0]  rem_d;
	logic [SW-1:0]              dslot_d;
	logic                       srej_pend_d;
	logic                       hole_d;
	logic [WINDOW_DEPTH-1:0]    valid_d;
	logic                       dlv_v_d;
	logic [srr_pkg::SEQ_W-1:0]  dlv_seq_d;

	logic [SW-1:0]              q_slot;
	logic [PAYLOAD_WIDTH-1:0]   q_pay;
	srr_pkg::cmd_t              q_cmd;
	logic                       wr_en;
	logic [SW-1:0]              rd_addr;
	logic [PAYLOAD_WIDTH-1:0]   rd_data;
	logic [srr_pkg::WORD_W-1:0] rd_word;
	logic [srr_pkg::WORD_W-1:0] q_word;
	logic [SW-1:0]              dslot_next;

	assign {q_slot, q_pay, q_cmd} = pop_data;

	srr_ram #(
		.WIDTH (PAYLOAD_WIDTH),
		.DEPTH (WINDOW_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (q_slot),
		.wr_data (q_pay),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		rd_word = '0;
		q_word  = '0;
		for (int b = 0; b < PAYLOAD_WIDTH; b++) begin
			if (b < srr_pkg::WORD_W) begin
				rd_word[b] = rd_data[b];
				q_word[b]  = q_pay[b];
			end
		end
	end

	assign dslot_next = (dslot_q == SW'(WINDOW_DEPTH - 1)) ? '0 : dslot_q + 1'b1;
	assign rd_addr    = dslot_q;

	always_comb begin
		state_d     = state_q;
		out_d       = '0;
		strobe_d    = 1'b0;
		msg2_d      = msg2_q;
		i_d         = i_q;
		rem_d       = rem_q;
		dslot_d     = dslot_q;
		srej_pend_d = srej_pend_q;
		hole_d      = hole_q;
		valid_d     = valid_q;
		dlv_v_d     = 1'b0;
		dlv_seq_d   = dlv_seq_s1;
		pop         = 1'b0;
		wr_en       = 1'b0;
		drain_done  = '0;

		// drained frame read last cycle, data now out of the RAM
		if (dlv_v_s1) begin
			out_d    = '{msg_kind: srr_pkg::KIND_DELIVER, number: dlv_seq_s1,
				payload_out: rd_word, last: 1'b0};
			strobe_d = 1'b1;
		end

		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					case (q_cmd.op)
						srr_pkg::OP_RR_DLV: begin
							out_d    = '{msg_kind: srr_pkg::KIND_RR, number: q_cmd.number,
								payload_out: '0, last: 1'b0};
							strobe_d = 1'b1;
							msg2_d   = '{msg_kind: srr_pkg::KIND_DELIVER, number: q_cmd.seq,
								payload_out: q_word, last: 1'b1};
							state_d  = ST_EMIT2;
						end
						srr_pkg::OP_STORE: begin
							wr_en           = 1'b1;
							valid_d[q_slot] = 1'b1;
							if (q_cmd.srej) begin
								out_d    = '{msg_kind: srr_pkg::KIND_SREJ,
									number: q_cmd.number, payload_out: '0, last: 1'b1};
								strobe_d = 1'b1;
							end
						end
						srr_pkg::OP_STALE: begin
							strobe_d = 1'b1;
							if (q_cmd.srej) begin
								out_d   = '{msg_kind: srr_pkg::KIND_SREJ, number: q_cmd.number,
									payload_out: '0, last: 1'b0};
								msg2_d  = '{msg_kind: srr_pkg::KIND_RR, number: q_cmd.number,
									payload_out: '0, last: 1'b1};
								state_d = ST_EMIT2;
							end else begin
								out_d   = '{msg_kind: srr_pkg::KIND_RR, number: q_cmd.number,
									payload_out: '0, last: 1'b1};
							end
						end
						srr_pkg::OP_EOF: begin
							out_d    = '{msg_kind: srr_pkg::KIND_EOFACK, number: '0,
								payload_out: '0, last: 1'b1};
							strobe_d = 1'b1;
						end
						srr_pkg::OP_DRAIN: begin
							wr_en           = 1'b1;
							valid_d[q_slot] = 1'b1;
							i_d             = q_cmd.seq;
							rem_d           = q_cmd.number;
							dslot_d         = q_slot;
							state_d         = ST_DRAIN;
						end
						default: begin
						end
					endcase
				end
			end
			ST_EMIT2: begin
				out_d    = msg2_q;
				strobe_d = 1'b1;
				state_d  = ST_IDLE;
			end
			ST_DRAIN: begin
				if (valid_q[dslot_q]) begin
					valid_d[dslot_q] = 1'b0;
					dlv_v_d          = 1'b1;
					dlv_seq_d        = i_q;
					i_d              = i_q + 1'b1;
					dslot_d          = dslot_next;
					if (rem_q == '0) begin
						// whole span delivered: window closes with a fresh RR
						srej_pend_d = 1'b0;
						hole_d      = 1'b0;
						state_d     = ST_DEND;
					end else begin
						rem_d = rem_q - 1'b1;
					end
				end else begin
					srej_pend_d = 1'b1;
					hole_d      = 1'b1;
					state_d     = ST_DEND;
				end
			end
			ST_DEND: begin
				// wait for the last delivery to leave before SREJ/RR
				if (!dlv_v_s1) begin
					strobe_d = 1'b1;
					if (srej_pend_q) begin
						out_d       = '{msg_kind: srr_pkg::KIND_SREJ, number: i_q,
							payload_out: '0, last: 1'b0};
						srej_pend_d = 1'b0;
					end else begin
						out_d      = '{msg_kind: srr_pkg::KIND_RR, number: i_q,
							payload_out: '0, last: 1'b1};
						drain_done = '{done: 1'b1, next_expected: i_q, srej_sent: hole_q};
						state_d    = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_q       <= '0;
			strobe_q    <= 1'b0;
			msg2_q      <= '0;
			i_q         <= '0;
			rem_q       <= '0;
			dslot_q     <= '0;
			srej_pend_q <= 1'b0;
			hole_q      <= 1'b0;
			valid_q     <= '0;
			dlv_v_s1    <= 1'b0;
			dlv_seq_s1  <= '0;
		end else begin
			state_q     <= state_d;
			out_q       <= out_d;
			strobe_q    <= strobe_d;
			msg2_q      <= msg2_d;
			i_q         <= i_d;
			rem_q       <= rem_d;
			dslot_q     <= dslot_d;
			srej_pend_q <= srej_pend_d;
			hole_q      <= hole_d;
			valid_q     <= valid_d;
			dlv_v_s1    <= dlv_v_d;
			dlv_seq_s1  <= dlv_seq_d;
		end
	end

	assign result        = out_q;
	assign result_strobe = strobe_q;

	a_done_then_rr: assert property (@(posedge clk) disable iff (!arst_n)
		drain_done.done |=> strobe_q && out_q.last && out_q.msg_kind == srr_pkg::KIND_RR)
		else $error("drain did not close with a final RR");

	a_drain_delivers_only: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN && strobe_q |->
			out_q.msg_kind == srr_pkg::KIND_DELIVER && !out_q.last)
		else $error("non-delivery result inside drain");

	a_read_then_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		dlv_v_s1 |=> strobe_q && out_q.msg_kind == srr_pkg::KIND_DELIVER)
		else $error("drained frame not delivered");

	a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !pop)
		else $error("command popped mid-sequence");

endmodule

FILE: rtl/selective_reject_receiver_core.sv
// An accepted frame passes two slot stages, the command queue and the result
//   register before its first result; then one result per cycle while queued commands yield results.
// Throughput: frames without a drain are taken back to back until the 4-entry
//   command queue fills; the executor emits at most 2 results per frame that needs no drain.
// A recovered frame holds busy until its drain ends and the new expected number is reported.
// Reset (arst_n low) clears window state, valid bits and the queue; the payload store is not cleared.
// ----------------------------------------------------------------------------
// selective_reject_receiver_core: selective-reject sliding-window receiver
// Classifier front end and executor back end joined by a command queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module selective_reject_receiver_core #(
	parameter  int unsigned WINDOW_DEPTH  = srr_pkg::WINDOW_DEPTH_DEF,
	parameter  int unsigned PAYLOAD_WIDTH = srr_pkg::PAYLOAD_WIDTH_DEF,
	parameter  int unsigned QUEUE_DEPTH   = srr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  srr_pkg::frame_t  frame,
	output srr_pkg::result_t result,
	output logic             result_strobe
);

	localparam int unsigned SW  = $clog2(WINDOW_DEPTH);
	localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned QW  = $bits(srr_pkg::cmd_t) + PAYLOAD_WIDTH + SW;

	logic                 push;
	logic [QW-1:0]        push_data;
	logic                 pop;
	logic [QW-1:0]        pop_data;
	logic                 q_empty;
	logic [QCW-1:0]       q_count;
	srr_pkg::drain_done_t drain_done;

	srr_front #(
		.WINDOW_DEPTH  (WINDOW_DEPTH),
		.PAYLOAD_WIDTH (PAYLOAD_WIDTH),
		.QUEUE_DEPTH   (QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.frame      (frame),
		.q_count    (q_count),
		.push       (push),
		.push_data  (push_data),
		.drain_done (drain_done)
	);

	srr_cmd_fifo #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty),
		.count     (q_count)
	);

	srr_back #(
		.WINDOW_DEPTH  (WINDOW_DEPTH),
		.PAYLOAD_WIDTH (PAYLOAD_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.pop           (pop),
		.pop_data      (pop_data),
		.drain_done    (drain_done),
		.result        (result),
		.result_strobe (result_strobe)
	);

endmodule
